FILE: rtl/arlp_pkg.sv
// ----------------------------------------------------------------------------
// arlp_pkg
// Shared types and constants of the AT response line parser.
// ----------------------------------------------------------------------------
package arlp_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_LINE    = 2'd0,
		PH_DIGITS  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_SKIP    = 2'd3
	} phase_t;

	// response kinds as seen on the result port
	typedef enum logic [3:0] {
		KIND_UNDEFINED  = 4'd0,
		KIND_SEND_OK    = 4'd1,
		KIND_OK         = 4'd2,
		KIND_RX_DATA    = 4'd3,
		KIND_ERROR      = 4'd4,
		KIND_FAIL       = 4'd5,
		KIND_ALREADY    = 4'd6,
		KIND_SEND_READY = 4'd7,
		KIND_BUSY       = 4'd8,
		KIND_SHORT      = 4'd9,
		KIND_OVERFLOW   = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic        is_payload;
		logic        last;
		logic [9:0]  payload_length;
	} result_t;

	localparam int unsigned PREFIX_LEN  = 7;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_PROMPT = 8'h3E;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	// keywords, left aligned in seven character slots (the +IPD, prefix in five)
	localparam logic [55:0] STR_OK      = {"OK", 40'h0};
	localparam logic [55:0] STR_SEND_OK = "SEND OK";
	localparam logic [55:0] STR_ERROR   = {"ERROR", 16'h0};
	localparam logic [55:0] STR_FAIL    = {"FAIL", 24'h0};
	localparam logic [55:0] STR_ALREADY = "ALREADY";
	localparam logic [55:0] STR_BUSY    = "busy...";
	localparam logic [39:0] STR_IPD     = "+IPD,";

endpackage

FILE: rtl/arlp_front.sv
// ----------------------------------------------------------------------------
// arlp_front
// Byte parser: line assembly, keyword classification, +IPD length decode and
// payload pass-through. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module arlp_front import arlp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD    = 512,
	parameter int unsigned MAX_LEN_DIGITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	output result_t     res
);

	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [19:0] MAX_LEN = 20'(MAX_PAYLOAD);
	localparam logic [2:0]  MAX_DIG = 3'(MAX_LEN_DIGITS);

	phase_t                      phase_q, phase_d;
	logic                        saw_cr_q, saw_cr_d;
	logic [PREFIX_LEN-1:0][7:0]  prefix_q;
	logic                        prefix_we;
	logic [3:0]                  count_q, count_d;
	logic [19:0]                 acc_q, acc_d;
	logic [2:0]                  digits_q, digits_d;
	logic [LEN_W-1:0]            remaining_q, remaining_d;
	logic [LEN_W-1:0]            frame_len_q;
	logic                        frame_load;

	logic        is_cr, is_lf, is_digit, is_colon, end_of_line, is_ipd;
	logic        len_ok, pay_last;
	logic [19:0] acc_x10, acc_next;
	kind_t       line_kind;

	function automatic logic starts_with(input logic [PREFIX_LEN-1:0][7:0] pre,
			input logic [3:0] cnt, input logic [55:0] str, input logic [3:0] len);
		logic hit;
		hit = (cnt >= len);
		for (int i = 0; i < PREFIX_LEN; i++) begin
			if ((4'(i) < len) && (pre[i] != str[55-8*i -: 8]))
				hit = 1'b0;
		end
		return hit;
	endfunction

	assign is_cr       = (rx_byte == CHAR_CR);
	assign is_lf       = (rx_byte == CHAR_LF);
	assign is_colon    = (rx_byte == CHAR_COLON);
	assign is_digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign end_of_line = is_lf && saw_cr_q;
	assign is_ipd      = (count_q == 4'd4) &&
		({prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3], rx_byte} == STR_IPD);
	assign acc_x10     = {acc_q[16:0], 3'b000} + {acc_q[18:0], 1'b0};
	assign acc_next    = acc_x10 + {16'h0, rx_byte[3:0]};
	assign len_ok      = (digits_q != 3'd0) && (acc_q != 20'd0) && (acc_q <= MAX_LEN);
	assign pay_last    = (remaining_q <= LEN_W'(1));

	always_comb begin
		if (starts_with(prefix_q, count_q, STR_OK, 4'd2))
			line_kind = KIND_OK;
		else if (starts_with(prefix_q, count_q, STR_SEND_OK, 4'd7))
			line_kind = KIND_SEND_OK;
		else if (starts_with(prefix_q, count_q, STR_ERROR, 4'd5))
			line_kind = KIND_ERROR;
		else if (starts_with(prefix_q, count_q, STR_FAIL, 4'd4))
			line_kind = KIND_FAIL;
		else if (starts_with(prefix_q, count_q, STR_ALREADY, 4'd7))
			line_kind = KIND_ALREADY;
		else if (starts_with(prefix_q, count_q, STR_BUSY, 4'd7))
			line_kind = KIND_BUSY;
		else if (count_q >= 4'd7)
			line_kind = KIND_UNDEFINED;
		else
			line_kind = KIND_SHORT;
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		saw_cr_d    = saw_cr_q;
		count_d     = count_q;
		acc_d       = acc_q;
		digits_d    = digits_q;
		remaining_d = remaining_q;
		prefix_we   = 1'b0;
		frame_load  = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				if (remaining_q != '0)
					remaining_d = remaining_q - LEN_W'(1);
				if (pay_last) begin
					phase_d  = PH_LINE;
					saw_cr_d = 1'b0;
					count_d  = 4'd0;
				end
			end
			PH_SKIP: begin
				if (end_of_line) begin
					phase_d  = PH_LINE;
					saw_cr_d = 1'b0;
					count_d  = 4'd0;
				end else begin
					saw_cr_d = is_cr;
				end
			end
			PH_DIGITS: begin
				if (is_digit && (digits_q < MAX_DIG)) begin
					acc_d    = acc_next;
					digits_d = digits_q + 3'd1;
				end else if (is_colon && len_ok) begin
					frame_load  = 1'b1;
					remaining_d = acc_q[LEN_W-1:0];
					phase_d     = PH_PAYLOAD;
					saw_cr_d    = 1'b0;
				end else begin
					phase_d  = PH_SKIP;
					saw_cr_d = is_cr;
				end
			end
			PH_LINE: begin
				if (is_cr) begin
					saw_cr_d = 1'b1;
				end else if (end_of_line) begin
					saw_cr_d = 1'b0;
					count_d  = 4'd0;
				end else begin
					saw_cr_d = 1'b0;
					if (!((count_q == 4'd0) && (rx_byte == CHAR_PROMPT))) begin
						prefix_we = (count_q < 4'(PREFIX_LEN));
						if (count_q != 4'd15)
							count_d = count_q + 4'd1;
						if (is_ipd) begin
							phase_d  = PH_DIGITS;
							acc_d    = 20'd0;
							digits_d = 3'd0;
						end
					end
				end
			end
			default: begin
				phase_d = PH_LINE;
			end
		endcase
	end

	// result
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = KIND_UNDEFINED;
		res.data_byte      = 8'h00;
		res.is_payload     = 1'b0;
		res.last           = 1'b0;
		res.payload_length = 10'd0;
		case (phase_q)
			PH_PAYLOAD: begin
				res_valid          = accept;
				res.kind           = KIND_RX_DATA;
				res.data_byte      = rx_byte;
				res.is_payload     = 1'b1;
				res.last           = pay_last;
				res.payload_length = 10'(frame_len_q);
			end
			PH_DIGITS: begin
				res_valid = accept && !(is_digit && (digits_q < MAX_DIG)) &&
					!(is_colon && len_ok);
			end
			PH_LINE: begin
				if (!is_cr && end_of_line && (count_q != 4'd0)) begin
					res_valid = accept;
					res.kind  = line_kind;
				end else if (!is_cr && !end_of_line && (count_q == 4'd0) &&
						(rx_byte == CHAR_PROMPT)) begin
					res_valid = accept;
					res.kind  = KIND_SEND_READY;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LINE;
			saw_cr_q    <= 1'b0;
			count_q     <= 4'd0;
			acc_q       <= 20'd0;
			digits_q    <= 3'd0;
			remaining_q <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			saw_cr_q    <= saw_cr_d;
			count_q     <= count_d;
			acc_q       <= acc_d;
			digits_q    <= digits_d;
			remaining_q <= remaining_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && prefix_we)
			prefix_q[count_q[2:0]] <= rx_byte;
		if (accept && frame_load)
			frame_len_q <= acc_q[LEN_W-1:0];
	end

	a_payload_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remaining_q != '0)
		else $error("payload phase with no bytes left");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_PAYLOAD && pay_last) |=> phase_q == PH_LINE && count_q == 4'd0)
		else $error("frame did not end after last payload byte");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGITS |-> digits_q <= MAX_DIG)
		else $error("length digit count out of range");

endmodule

FILE: rtl/arlp_queue.sv
// ----------------------------------------------------------------------------
// arlp_queue
// Result queue between the parser and the result port; each side stalls on
// its own.
// ----------------------------------------------------------------------------
module arlp_queue import arlp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  result_t  wdata,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output result_t  rdata
);

	result_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q, rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (!push && do_pop)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= wdata;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("transaction pushed into a full result queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue count out of range");

endmodule

FILE: rtl/at_response_line_parser.sv
// ----------------------------------------------------------------------------
// at_response_line_parser
// Modem AT response parser: one received byte in, at most one result out.
// ----------------------------------------------------------------------------
// The block takes one byte every clock cycle while full is low; a byte's
// result, if it has one, is in the four-entry result queue from the cycle
// after the byte was taken and stays there until popped. The parser keeps the
// first seven characters of a line and classifies it on CR LF in the same
// cycle, so the rate is set only by the result queue: full rises after four
// results wait unpopped. Payload bytes after +IPD,<len>: come out one result
// per byte, the last one marked.
// ----------------------------------------------------------------------------
module at_response_line_parser import arlp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD    = 512,
	parameter int unsigned MAX_LEN_DIGITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  kind,
	output logic [7:0]  data_byte,
	output logic        is_payload,
	output logic        last,
	output logic [9:0]  payload_length
);

	logic     accept;
	logic     res_valid;
	result_t  res;
	result_t  head;

	assign accept = push && !full;

	arlp_front #(
		.MAX_PAYLOAD    (MAX_PAYLOAD),
		.MAX_LEN_DIGITS (MAX_LEN_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	arlp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head)
	);

	assign kind           = head.kind;
	assign data_byte      = head.data_byte;
	assign is_payload     = head.is_payload;
	assign last           = head.last;
	assign payload_length = head.payload_length;

endmodule
